FILE: sv/hashed_hypercube_vertex_projector_core_assert.svh
// Assertion macros shared by the projector checker.
`ifndef HASHED_HYPERCUBE_VERTEX_PROJECTOR_CORE_ASSERT_SVH
`define HASHED_HYPERCUBE_VERTEX_PROJECTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define HHVP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define HHVP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/hhvp_pkg.sv
// Package: constants, types and table functions of the vertex projector.
`default_nettype none
package hhvp_pkg;

    localparam int DIMENSIONS_DEF = 7;
    localparam int DIMENSIONS_MAX = 16;
    localparam logic [31:0] MIX_C1 = 32'h7feb352d;
    localparam logic [31:0] MIX_C2 = 32'h846ca68b;
    localparam logic [31:0] DIM_MULT = 32'd73856093;
    localparam int CORDIC_STEPS = 24;
    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    localparam logic [31:0] FRAME_SEED_RST = 32'd0;
    localparam logic signed [15:0] COS_ANGLE_RST = 16'sd16384;
    localparam logic signed [15:0] SIN_ANGLE_RST = 16'sd0;
    localparam logic [19:0] SCALE_RST = 20'd256;
    localparam logic [18:0] CENTER_RST = 19'd0;

    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_FRAME_SEED = 3'd0,
        REG_COS_ANGLE  = 3'd1,
        REG_SIN_ANGLE  = 3'd2,
        REG_SCALE      = 3'd3,
        REG_CENTER_X   = 3'd4,
        REG_CENTER_Y   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] s;
    } trig_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    function automatic logic signed [15:0] to_q14(input longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 64'sd16384) r = 64'sd16384;
        if (r < -64'sd16384) r = -64'sd16384;
        return 16'(r);
    endfunction

    function automatic trig_t cordic_trig(input logic [31:0] a);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint c;
        longint s;
        trig_t t;
        x = CORDIC_GAIN;
        y = 0;
        z = longint'({34'd0, a[29:0]});
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - ATAN_TURNS[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + ATAN_TURNS[i];
            end
        end
        case (a[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        t.c = to_q14(c);
        t.s = to_q14(s);
        return t;
    endfunction

    function automatic logic [2:0] mod6(input logic [5:0] p);
        logic [5:0] v;
        v = p;
        if (v >= 6'd24) v = v - 6'd24;
        if (v >= 6'd12) v = v - 6'd12;
        if (v >= 6'd6) v = v - 6'd6;
        return v[2:0];
    endfunction

    function automatic color_t palette(input logic [2:0] i);
        color_t c;
        case (i)
            3'd0: c = '{blue: 8'd80,  green: 8'd80,  red: 8'd255};
            3'd1: c = '{blue: 8'd0,   green: 8'd180, red: 8'd255};
            3'd2: c = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
            3'd3: c = '{blue: 8'd80,  green: 8'd255, red: 8'd80};
            3'd4: c = '{blue: 8'd255, green: 8'd255, red: 8'd0};
            3'd5: c = '{blue: 8'd255, green: 8'd120, red: 8'd180};
            default: c = '{blue: 8'd0, green: 8'd0, red: 8'd0};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: sv/hhvp_mix.sv
// Two-stage pipelined xorshift-multiply hash of one 32-bit word.
`default_nettype none
module hhvp_mix
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] din,
    output logic      [31:0] dout
);

    logic [31:0] m1_reg;
    logic [31:0] m1_next;
    logic [31:0] m2_reg;
    logic [31:0] m2_next;
    logic [31:0] x1;
    logic [31:0] x2;

    assign x1 = din ^ (din >> 16);
    assign m1_next = x1 * hhvp_pkg::MIX_C1;
    assign x2 = m1_reg ^ (m1_reg >> 15);
    assign m2_next = x2 * hhvp_pkg::MIX_C2;
    assign dout = m2_reg ^ (m2_reg >> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/hashed_hypercube_vertex_projector_core.sv
// Top level of the hashed hypercube vertex projector pipeline.
//
// Stream in: s_tvalid/s_tready/s_tdata, one vertex index per transfer.
// Stream out: m_tvalid/m_tready/m_tdata, one projected, colored point per
// input transfer, in input order.
// From the input transfer to m_tvalid an item passes two hash stages
// for the seed, two for the per-dimension hashes, the sign sum, the rotation
// products, the rotation sums, the split scale products, rounding, and the
// center add with saturation into the output register.
// Throughput is one item per cycle unless the receiver stalls; every stage holds at most one multiplier level.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// s_tready is high whenever the output register is empty or being taken.
// The user must write registers over the APB port only while the pipeline is empty; the block does not enforce it.
// Reset clears all valid bits and loads the register defaults: frame_seed 0,
// cos_angle 16384, sin_angle 0, scale 256, centers 0.
// The cos and sin tables per dimension are fixed at elaboration.
`default_nettype none
module hashed_hypercube_vertex_projector_core
#(
    parameter int DIMENSIONS = hhvp_pkg::DIMENSIONS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [15:0]                  s_tdata,  // vertex_index
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // screen_x[19:0], screen_y[39:20], red[47:40], green[55:48], blue[63:56]
    output logic      [63:0]                  m_tdata,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hhvp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    localparam int SUM_W = $clog2(DIMENSIONS * 16384 + 1) + 1;
    localparam int PROD_W = SUM_W + 16;
    localparam int R_W = PROD_W + 1;
    localparam int HI_W = R_W - 18;
    localparam int HIP_W = HI_W + 21;
    localparam int P_W = 58;
    localparam int T_W = P_W - 32;
    localparam int V_W = T_W + 1;
    localparam int STAGES = 10;

    logic [31:0]        frame_seed_reg;
    logic signed [15:0] cos_angle_reg;
    logic signed [15:0] sin_angle_reg;
    logic [19:0]        scale_reg;
    logic [18:0]        center_x_reg;
    logic [18:0]        center_y_reg;
    logic               wr_en;
    hhvp_pkg::reg_idx_t wr_idx;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;
    assign wr_idx = hhvp_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_seed_reg <= hhvp_pkg::FRAME_SEED_RST;
            cos_angle_reg  <= hhvp_pkg::COS_ANGLE_RST;
            sin_angle_reg  <= hhvp_pkg::SIN_ANGLE_RST;
            scale_reg      <= hhvp_pkg::SCALE_RST;
            center_x_reg   <= hhvp_pkg::CENTER_RST;
            center_y_reg   <= hhvp_pkg::CENTER_RST;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                hhvp_pkg::REG_FRAME_SEED: frame_seed_reg <= pwdata;
                hhvp_pkg::REG_COS_ANGLE:  cos_angle_reg <= pwdata[15:0];
                hhvp_pkg::REG_SIN_ANGLE:  sin_angle_reg <= pwdata[15:0];
                hhvp_pkg::REG_SCALE:      scale_reg <= pwdata[19:0];
                hhvp_pkg::REG_CENTER_X:   center_x_reg <= pwdata[18:0];
                hhvp_pkg::REG_CENTER_Y:   center_y_reg <= pwdata[18:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            hhvp_pkg::REG_FRAME_SEED: prdata = frame_seed_reg;
            hhvp_pkg::REG_COS_ANGLE:  prdata = {16'd0, cos_angle_reg};
            hhvp_pkg::REG_SIN_ANGLE:  prdata = {16'd0, sin_angle_reg};
            hhvp_pkg::REG_SCALE:      prdata = {12'd0, scale_reg};
            hhvp_pkg::REG_CENTER_X:   prdata = {13'd0, center_x_reg};
            hhvp_pkg::REG_CENTER_Y:   prdata = {13'd0, center_y_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Pipeline control
    logic [STAGES-1:0] vld_reg;
    logic              adv;

    assign adv = !vld_reg[STAGES-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[STAGES-2:0], s_tvalid};
    end

    // Seed hash
    logic [31:0] seed;

    hhvp_mix u_seed
    (
        .clk  (clk),
        .en   (adv),
        .din  ({16'd0, s_tdata} + frame_seed_reg),
        .dout (seed)
    );

    // Per-dimension hashes and constant tables
    logic signed [15:0]  tab_cos [DIMENSIONS];
    logic signed [15:0]  tab_sin [DIMENSIONS];
    logic [DIMENSIONS-1:0] sgn;

    for (genvar d = 0; d < DIMENSIONS; d++)
    begin : g_dim
        localparam logic [31:0] ANG = 32'((64'(d) << 32) / DIMENSIONS);
        localparam hhvp_pkg::trig_t TRIG = hhvp_pkg::cordic_trig(ANG);
        localparam logic [31:0] OFS = 32'(64'(d) * 64'(hhvp_pkg::DIM_MULT));
        logic [31:0] h;

        assign tab_cos[d] = TRIG.c;
        assign tab_sin[d] = TRIG.s;

        hhvp_mix u_mix
        (
            .clk  (clk),
            .en   (adv),
            .din  (seed + OFS),
            .dout (h)
        );

        assign sgn[d] = h[0];
    end

    logic [5:0] pop3_reg;
    logic [5:0] pop4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pop3_reg <= 6'($countones(seed));
            pop4_reg <= pop3_reg;
        end
    end

    // Sign sum
    logic signed [SUM_W-1:0] sc_next;
    logic signed [SUM_W-1:0] ss_next;
    logic signed [SUM_W-1:0] sc_reg;
    logic signed [SUM_W-1:0] ss_reg;
    hhvp_pkg::color_t        col_reg [4:STAGES-1];

    always_comb
    begin
        sc_next = '0;
        ss_next = '0;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            if (sgn[d])
            begin
                sc_next = sc_next + SUM_W'(tab_cos[d]);
                ss_next = ss_next + SUM_W'(tab_sin[d]);
            end
            else
            begin
                sc_next = sc_next - SUM_W'(tab_cos[d]);
                ss_next = ss_next - SUM_W'(tab_sin[d]);
            end
        end
    end

    // Rotation, scale, rounding, center add with saturation
    logic signed [PROD_W-1:0] p_cc_reg;
    logic signed [PROD_W-1:0] p_ss_reg;
    logic signed [PROD_W-1:0] p_cs_reg;
    logic signed [PROD_W-1:0] p_sc_reg;
    logic signed [R_W-1:0]    rx_reg;
    logic signed [R_W-1:0]    ry_reg;
    logic signed [20:0]       scl_s;
    logic signed [HI_W-1:0]   rx_hi;
    logic signed [HI_W-1:0]   ry_hi;
    logic [37:0]              lo_x_reg;
    logic [37:0]              lo_y_reg;
    logic signed [HIP_W-1:0]  hi_x_reg;
    logic signed [HIP_W-1:0]  hi_y_reg;
    logic signed [P_W-1:0]    px;
    logic signed [P_W-1:0]    py;
    logic signed [T_W-1:0]    tx_reg;
    logic signed [T_W-1:0]    ty_reg;
    logic signed [V_W-1:0]    vx;
    logic signed [V_W-1:0]    vy;
    logic signed [19:0]       sx_reg;
    logic signed [19:0]       sy_reg;

    assign scl_s = {1'b0, scale_reg};
    assign rx_hi = rx_reg[R_W-1:18];
    assign ry_hi = ry_reg[R_W-1:18];
    assign px = (P_W'(hi_x_reg) <<< 18) + P_W'(lo_x_reg) + P_W'(64'h8000_0000);
    assign py = (P_W'(hi_y_reg) <<< 18) + P_W'(lo_y_reg) + P_W'(64'h8000_0000);
    assign vx = V_W'(tx_reg) + V_W'($signed({1'b0, center_x_reg}));
    assign vy = V_W'(ty_reg) + V_W'($signed({1'b0, center_y_reg}));

    function automatic logic signed [19:0] sat20(input logic signed [V_W-1:0] v);
        if (v > V_W'(524287))
            return 20'sh7FFFF;
        if (v < -V_W'(524288))
            return 20'sh80000;
        return v[19:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_reg   <= sc_next;
            ss_reg   <= ss_next;
            col_reg[4] <= hhvp_pkg::palette(hhvp_pkg::mod6(pop4_reg));
            for (int i = 5; i < STAGES; i++)
                col_reg[i] <= col_reg[i-1];
            p_cc_reg <= PROD_W'(sc_reg) * PROD_W'(cos_angle_reg);
            p_ss_reg <= PROD_W'(ss_reg) * PROD_W'(sin_angle_reg);
            p_cs_reg <= PROD_W'(sc_reg) * PROD_W'(sin_angle_reg);
            p_sc_reg <= PROD_W'(ss_reg) * PROD_W'(cos_angle_reg);
            rx_reg   <= R_W'(p_cc_reg) - R_W'(p_ss_reg);
            ry_reg   <= R_W'(p_cs_reg) + R_W'(p_sc_reg);
            lo_x_reg <= 38'(rx_reg[17:0]) * 38'(scale_reg);
            lo_y_reg <= 38'(ry_reg[17:0]) * 38'(scale_reg);
            hi_x_reg <= HIP_W'(rx_hi) * HIP_W'(scl_s);
            hi_y_reg <= HIP_W'(ry_hi) * HIP_W'(scl_s);
            tx_reg   <= px[P_W-1:32];
            ty_reg   <= py[P_W-1:32];
            sx_reg   <= sat20(vx);
            sy_reg   <= sat20(vy);
        end
    end

    assign m_tdata = {col_reg[STAGES-1].blue, col_reg[STAGES-1].green,
                      col_reg[STAGES-1].red, sy_reg, sx_reg};

endmodule
`default_nettype wire

FILE: sv/hhvp_checker.sv
// Port-level checker for the projector, bound to the top level.
`default_nettype none
`include "hashed_hypercube_vertex_projector_core_assert.svh"
module hhvp_assert_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    `HHVP_ASSERT_NOW(a_ready_follows_sink, m_tready, s_tready)
    `HHVP_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)
    `HHVP_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind hashed_hypercube_vertex_projector_core hhvp_assert_checker u_hhvp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

FILE: verif/hhvp_checker.sv
// Checker: predicts projected points from the vertex stream and compares results.
`default_nettype none
module hhvp_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [hhvp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending,
    output int               points_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NDIM = hhvp_pkg::DIMENSIONS_DEF;

    logic [31:0] seed_reg;
    logic [15:0] cos_reg;
    logic [15:0] sin_reg;
    logic [19:0] scale_reg;
    logic [18:0] cx_reg;
    logic [18:0] cy_reg;
    longint dir_cos [NDIM];
    longint dir_sin [NDIM];
    logic [63:0] point_q [$];

    function automatic longint shr_floor(input longint v, input int n);
        if (v >= 0)
            return v >>> n;
        return -((-(v + 1)) >>> n) - 1;
    endfunction

    function automatic longint q14_round(input longint v);
        longint r;
        r = shr_floor(v + 32768, 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    function automatic logic [31:0] hash32(input logic [31:0] v);
        logic [31:0] x;
        x = v;
        x = x ^ (x >> 16);
        x = x * 32'h7feb352d;
        x = x ^ (x >> 15);
        x = x * 32'h846ca68b;
        x = x ^ (x >> 16);
        return x;
    endfunction

    task automatic build_directions();
        logic [31:0] a;
        longint x, y, z, dx, dy, c, s;
        for (int d = 0; d < NDIM; d++)
        begin
            a = 32'((64'(d) << 32) / NDIM);
            z = longint'(a & 32'h3FFFFFFF);
            x = 652032874;
            y = 0;
            for (int i = 0; i < hhvp_pkg::CORDIC_STEPS; i++)
            begin
                dx = shr_floor(y, i);
                dy = shr_floor(x, i);
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= hhvp_pkg::ATAN_TURNS[i];
                end
                else
                begin
                    x += dx; y -= dy; z += hhvp_pkg::ATAN_TURNS[i];
                end
            end
            case (a[31:30])
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            dir_cos[d] = q14_round(c);
            dir_sin[d] = q14_round(s);
        end
    endtask

    function automatic logic [19:0] place_axis(input longint r, input logic [18:0] ctr);
        longint p, v;
        p = r * longint'({44'd0, scale_reg});
        v = shr_floor(p + (64'sd1 <<< 31), 32) + longint'({45'd0, ctr});
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[19:0];
    endfunction

    function automatic logic [63:0] project_vertex(input logic [15:0] idx);
        logic [31:0] seed, h;
        longint sc, ss, ca, sa, rx, ry;
        int pop;
        logic [7:0] r, g, b;
        seed = hash32({16'd0, idx} + seed_reg);
        sc = 0;
        ss = 0;
        for (int d = 0; d < NDIM; d++)
        begin
            h = hash32(seed + 32'(d) * hhvp_pkg::DIM_MULT);
            if (h[0])
            begin
                sc += dir_cos[d]; ss += dir_sin[d];
            end
            else
            begin
                sc -= dir_cos[d]; ss -= dir_sin[d];
            end
        end
        ca = longint'(signed'(cos_reg));
        sa = longint'(signed'(sin_reg));
        rx = sc * ca - ss * sa;
        ry = sc * sa + ss * ca;
        pop = $countones(seed);
        case (pop % 6)
            0: begin r = 255; g = 80;  b = 80;  end
            1: begin r = 255; g = 180; b = 0;   end
            2: begin r = 255; g = 255; b = 0;   end
            3: begin r = 80;  g = 255; b = 80;  end
            4: begin r = 0;   g = 255; b = 255; end
            default: begin r = 180; g = 120; b = 255; end
        endcase
        return {b, g, r, place_axis(ry, cy_reg), place_axis(rx, cx_reg)};
    endfunction

    initial
    begin
        build_directions();
    end

    assign pending = point_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] exp_pt;
        if (!rst_n)
        begin
            seed_reg <= hhvp_pkg::FRAME_SEED_RST;
            cos_reg <= hhvp_pkg::COS_ANGLE_RST;
            sin_reg <= hhvp_pkg::SIN_ANGLE_RST;
            scale_reg <= hhvp_pkg::SCALE_RST;
            cx_reg <= hhvp_pkg::CENTER_RST;
            cy_reg <= hhvp_pkg::CENTER_RST;
            fail_count <= 0;
            points_seen <= 0;
            point_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                point_q.push_back(project_vertex(s_tdata));
            if (m_tvalid && m_tready)
            begin
                points_seen <= points_seen + 1;
                if (point_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected point %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_pt = point_q.pop_front();
                    if (exp_pt !== m_tdata)
                    begin
                        if (fail_count < 10)
                            $display("point mismatch: exp x=%h y=%h rgb=%h act x=%h y=%h rgb=%h",
                                exp_pt[19:0], exp_pt[39:20], exp_pt[63:40],
                                m_tdata[19:0], m_tdata[39:20], m_tdata[63:40]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (hhvp_pkg::reg_idx_t'(paddr[4:2]))
                    hhvp_pkg::REG_FRAME_SEED: seed_reg <= pwdata;
                    hhvp_pkg::REG_COS_ANGLE:  cos_reg <= pwdata[15:0];
                    hhvp_pkg::REG_SIN_ANGLE:  sin_reg <= pwdata[15:0];
                    hhvp_pkg::REG_SCALE:      scale_reg <= pwdata[19:0];
                    hhvp_pkg::REG_CENTER_X:   cx_reg <= pwdata[18:0];
                    hhvp_pkg::REG_CENTER_Y:   cy_reg <= pwdata[18:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Testbench top: drives vertex transfers and register writes, reports the verdict.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [hhvp_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count;
    int pending;
    int points_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hashed_hypercube_vertex_projector_core u_top (.*);

    hhvp_checker u_chk (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (cycle_count > 400000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic reg_write(input hhvp_pkg::reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_vertex(input logic [15:0] idx);
        while (($urandom_range(99) < send_idle_pct))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= idx;
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    task automatic random_settings(input int mode);
        reg_write(hhvp_pkg::REG_FRAME_SEED, $urandom());
        case (mode)
            0: begin
                reg_write(hhvp_pkg::REG_COS_ANGLE, 32'(-16384));
                reg_write(hhvp_pkg::REG_SIN_ANGLE, 32'd16384);
                reg_write(hhvp_pkg::REG_SCALE, 32'hFFFFF);
                reg_write(hhvp_pkg::REG_CENTER_X, 32'h7FFFF);
                reg_write(hhvp_pkg::REG_CENTER_Y, 32'd0);
            end
            1: begin
                reg_write(hhvp_pkg::REG_COS_ANGLE, $urandom());
                reg_write(hhvp_pkg::REG_SIN_ANGLE, $urandom());
                reg_write(hhvp_pkg::REG_SCALE, $urandom());
                reg_write(hhvp_pkg::REG_CENTER_X, $urandom());
                reg_write(hhvp_pkg::REG_CENTER_Y, $urandom());
            end
            default: begin
                reg_write(hhvp_pkg::REG_COS_ANGLE, 32'($urandom_range(32768)) - 32'd16384);
                reg_write(hhvp_pkg::REG_SIN_ANGLE, 32'($urandom_range(32768)) - 32'd16384);
                reg_write(hhvp_pkg::REG_SCALE, $urandom_range(8192));
                reg_write(hhvp_pkg::REG_CENTER_X, $urandom_range(16384, 0));
                reg_write(hhvp_pkg::REG_CENTER_Y, $urandom_range(524287, 262144));
            end
        endcase
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        send_vertex(16'h0000);
        send_vertex(16'hFFFF);
        send_vertex(16'h5555);
        send_vertex(16'hAAAA);
        drain();
        reg_write(hhvp_pkg::REG_FRAME_SEED, 32'hFFFFFFFF);
        reg_write(hhvp_pkg::REG_COS_ANGLE, 32'h00008000);
        reg_write(hhvp_pkg::REG_SIN_ANGLE, 32'h00007FFF);
        reg_write(hhvp_pkg::REG_SCALE, 32'hFFFFF);
        reg_write(hhvp_pkg::REG_CENTER_X, 32'h7FFFF);
        reg_write(hhvp_pkg::REG_CENTER_Y, 32'h7FFFF);
        for (int i = 0; i < 8; i++)
            send_vertex(16'(i));
        send_vertex(16'hFFFF);
        drain();
        reg_write(hhvp_pkg::REG_SCALE, 32'd0);
        reg_write(hhvp_pkg::REG_CENTER_X, 32'd0);
        reg_write(hhvp_pkg::REG_CENTER_Y, 32'd0);
        send_vertex(16'h1234);
        send_vertex(16'hFFFF);
        drain();
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 3)
                0: begin send_idle_pct = 35; recv_idle_pct = 62; end
                1: begin send_idle_pct = 62; recv_idle_pct = 35; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            random_settings(ph % 4 == 3 ? 0 : ph % 2 + 1);
            for (int k = 0; k < 115; k++)
                send_vertex(16'($urandom()));
            drain();
        end
        $display("Sent %0d vertices over 12 register settings; %0d points checked.",
            sent, points_seen);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/hhvp_pkg.sv
sv/hhvp_mix.sv
sv/hashed_hypercube_vertex_projector_core.sv
sv/hhvp_checker.sv
verif/hhvp_checker.sv
verif/testbench.sv
